// File: sv/bcru_pkg.sv
// ----------------------------------------------------------------------------
// bcru_pkg
// Shared types and constants for the branch/call/return unit: opcode codes,
// flag bit positions, instruction classes and the decoded queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package bcru_pkg;

	// Opcode codes (unprefixed)
	localparam logic [7:0] OP_MASK_CC = 8'hC7;
	localparam logic [7:0] OP_JP_CC   = 8'hC2;
	localparam logic [7:0] OP_CALL_CC = 8'hC4;
	localparam logic [7:0] OP_RET_CC  = 8'hC0;
	localparam logic [7:0] OP_JP      = 8'hC3;
	localparam logic [7:0] OP_JP_HL   = 8'hE9;
	localparam logic [7:0] OP_CALL    = 8'hCD;
	localparam logic [7:0] OP_RET     = 8'hC9;
	localparam logic [7:0] OP_DI      = 8'hF3;
	localparam logic [7:0] OP_EI      = 8'hFB;

	// Opcode codes (after ED prefix)
	localparam logic [7:0] OP_IM0 = 8'h46;
	localparam logic [7:0] OP_IM1 = 8'h56;
	localparam logic [7:0] OP_IM2 = 8'h5E;

	// Flag bit positions
	localparam int FLG_S  = 7;
	localparam int FLG_Z  = 6;
	localparam int FLG_PV = 2;
	localparam int FLG_C  = 0;

	// Interrupt modes
	localparam logic [1:0] IM_MODE0 = 2'd0;
	localparam logic [1:0] IM_MODE1 = 2'd1;
	localparam logic [1:0] IM_MODE2 = 2'd2;

	// Instruction length offsets and stack step
	localparam logic [15:0] LEN1     = 16'd1;
	localparam logic [15:0] LEN2     = 16'd2;
	localparam logic [15:0] LEN3     = 16'd3;
	localparam logic [15:0] SP_STEP  = 16'd2;

	// Extra cycle counts
	localparam logic [2:0] EXTRA_NONE = 3'd0;
	localparam logic [2:0] EXTRA_RETC = 3'd6;
	localparam logic [2:0] EXTRA_CALL = 3'd7;

	// Decoupling queue depth
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// Instruction classes
	typedef enum logic [2:0] {
		CLS_UNREC = 3'd0,
		CLS_JUMP  = 3'd1,
		CLS_CALL  = 3'd2,
		CLS_RETC  = 3'd3,
		CLS_RET   = 3'd4,
		CLS_DI    = 3'd5,
		CLS_EI    = 3'd6,
		CLS_IM    = 3'd7
	} cls_t;

	// Decoded instruction as it travels from front to back
	typedef struct packed {
		cls_t        cls;
		logic        tk;      // condition resolved: jump/call/return taken
		logic [1:0]  mode;    // new interrupt mode for IM
		logic [15:0] pc;
		logic [15:0] sp;
		logic [15:0] target;  // immediate, HL or stack word as the class needs
	} entry_t;

endpackage

`default_nettype wire

// File: sv/bcru_front.sv
// ----------------------------------------------------------------------------
// bcru_front
// Decode stage: classifies the opcode, resolves the branch condition against
// the flags and picks the jump target, producing one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bcru_front
	import bcru_pkg::*;
(
	input  wire logic [7:0]  opcode,
	input  wire logic        ed_prefix,
	input  wire logic [7:0]  flags,
	input  wire logic [15:0] pc,
	input  wire logic [15:0] sp,
	input  wire logic [15:0] hl,
	input  wire logic [15:0] immediate,
	input  wire logic [15:0] stack_word,
	output entry_t           entry
);

	logic [2:0] sel;
	logic       flag_bit;
	logic       cond;

	// Condition: opcode bits 5..3 pick flag and polarity (odd = flag set)
	assign sel = opcode[5:3];

	always_comb begin
		unique case (sel[2:1])
			2'd0:    flag_bit = flags[FLG_Z];
			2'd1:    flag_bit = flags[FLG_C];
			2'd2:    flag_bit = flags[FLG_PV];
			default: flag_bit = flags[FLG_S];
		endcase
	end

	assign cond = sel[0] ? flag_bit : ~flag_bit;

	// Classification
	always_comb begin
		entry        = '0;
		entry.cls    = CLS_UNREC;
		entry.tk     = 1'b0;
		entry.mode   = IM_MODE0;
		entry.pc     = pc;
		entry.sp     = sp;
		entry.target = immediate;
		if (ed_prefix) begin
			unique case (opcode)
				OP_IM0: begin
					entry.cls  = CLS_IM;
					entry.mode = IM_MODE0;
				end
				OP_IM1: begin
					entry.cls  = CLS_IM;
					entry.mode = IM_MODE1;
				end
				OP_IM2: begin
					entry.cls  = CLS_IM;
					entry.mode = IM_MODE2;
				end
				default: entry.cls = CLS_UNREC;
			endcase
		end else begin
			priority if ((opcode & OP_MASK_CC) == OP_JP_CC || opcode == OP_JP) begin
				entry.cls = CLS_JUMP;
				entry.tk  = (opcode == OP_JP) | cond;
			end else if (opcode == OP_JP_HL) begin
				entry.cls    = CLS_JUMP;
				entry.tk     = 1'b1;
				entry.target = hl;
			end else if ((opcode & OP_MASK_CC) == OP_CALL_CC || opcode == OP_CALL) begin
				entry.cls = CLS_CALL;
				entry.tk  = (opcode == OP_CALL) | cond;
			end else if ((opcode & OP_MASK_CC) == OP_RET_CC) begin
				entry.cls    = CLS_RETC;
				entry.tk     = cond;
				entry.target = stack_word;
			end else if (opcode == OP_RET) begin
				entry.cls    = CLS_RET;
				entry.tk     = 1'b1;
				entry.target = stack_word;
			end else if (opcode == OP_DI) begin
				entry.cls = CLS_DI;
			end else if (opcode == OP_EI) begin
				entry.cls = CLS_EI;
			end else begin
				entry.cls = CLS_UNREC;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/bcru_queue.sv
// ----------------------------------------------------------------------------
// bcru_queue
// Short FIFO of decoded entries between the decode and execute stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bcru_queue
	import bcru_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  entry_t      push_data,
	input  wire logic   pop,
	output logic        not_empty,
	output logic        full,
	output entry_t      head
);

	entry_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/bcru_back.sv
// ----------------------------------------------------------------------------
// bcru_back
// Execute stage: computes next PC/SP and the push request, keeps the
// interrupt flip-flops and mode, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcru_back
	import bcru_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	input  entry_t            head,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [15:0]       next_pc,
	output logic [15:0]       next_sp,
	output logic              push_valid,
	output logic [15:0]       push_word,
	output logic              taken,
	output logic [2:0]        extra_cycles,
	output logic              iff1_out,
	output logic              iff2_out,
	output logic [1:0]        int_mode_out,
	output logic              recognized
);

	logic        valid_q;
	logic        iff1_q;
	logic        iff2_q;
	logic [1:0]  int_mode_q;
	logic        load;

	logic [15:0] pc_len1;
	logic [15:0] pc_len2;
	logic [15:0] pc_len3;
	logic [15:0] sp_dec;
	logic [15:0] sp_inc;

	logic [15:0] npc;
	logic [15:0] nsp;
	logic        pv;
	logic [15:0] pw;
	logic        tk;
	logic [2:0]  ex;
	logic        rec;
	logic        iff1_d;
	logic        iff2_d;
	logic [1:0]  mode_d;

	logic [15:0] next_pc_q;
	logic [15:0] next_sp_q;
	logic        push_valid_q;
	logic [15:0] push_word_q;
	logic        taken_q;
	logic [2:0]  extra_q;
	logic        recognized_q;

	// Take the queue head whenever the output register is free or draining
	assign load  = q_valid & (~valid_q | out_ready);
	assign q_pop = load;

	// Address arithmetic, wraps modulo 2^16
	assign pc_len1 = head.pc + LEN1;
	assign pc_len2 = head.pc + LEN2;
	assign pc_len3 = head.pc + LEN3;
	assign sp_dec  = head.sp - SP_STEP;
	assign sp_inc  = head.sp + SP_STEP;

	// Execute
	always_comb begin
		npc    = head.pc;
		nsp    = head.sp;
		pv     = 1'b0;
		pw     = '0;
		tk     = 1'b0;
		ex     = EXTRA_NONE;
		rec    = 1'b1;
		iff1_d = iff1_q;
		iff2_d = iff2_q;
		mode_d = int_mode_q;
		unique case (head.cls)
			CLS_JUMP: begin
				npc = head.tk ? head.target : pc_len3;
				tk  = head.tk;
			end
			CLS_CALL: begin
				if (head.tk) begin
					nsp = sp_dec;
					pv  = 1'b1;
					pw  = pc_len3;
					npc = head.target;
					tk  = 1'b1;
					ex  = EXTRA_CALL;
				end else begin
					npc = pc_len3;
				end
			end
			CLS_RETC: begin
				if (head.tk) begin
					npc = head.target;
					nsp = sp_inc;
					tk  = 1'b1;
					ex  = EXTRA_RETC;
				end else begin
					npc = pc_len1;
				end
			end
			CLS_RET: begin
				npc = head.target;
				nsp = sp_inc;
				tk  = 1'b1;
			end
			CLS_DI: begin
				iff1_d = 1'b0;
				iff2_d = 1'b0;
				npc    = pc_len1;
			end
			CLS_EI: begin
				iff1_d = 1'b1;
				iff2_d = 1'b1;
				npc    = pc_len1;
			end
			CLS_IM: begin
				mode_d = head.mode;
				npc    = pc_len2;
			end
			default: begin
				rec = 1'b0;
			end
		endcase
	end

	// Control state: output valid and interrupt state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			iff1_q     <= 1'b0;
			iff2_q     <= 1'b0;
			int_mode_q <= IM_MODE0;
		end else begin
			if (load) begin
				valid_q    <= 1'b1;
				iff1_q     <= iff1_d;
				iff2_q     <= iff2_d;
				int_mode_q <= mode_d;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			next_pc_q    <= npc;
			next_sp_q    <= nsp;
			push_valid_q <= pv;
			push_word_q  <= pw;
			taken_q      <= tk;
			extra_q      <= ex;
			recognized_q <= rec;
		end
	end

	assign out_valid    = valid_q;
	assign next_pc      = next_pc_q;
	assign next_sp      = next_sp_q;
	assign push_valid   = push_valid_q;
	assign push_word    = push_word_q;
	assign taken        = taken_q;
	assign extra_cycles = extra_q;
	assign iff1_out     = iff1_q;
	assign iff2_out     = iff2_q;
	assign int_mode_out = int_mode_q;
	assign recognized   = recognized_q;

endmodule

`default_nettype wire

// File: sv/cpu_branch_call_return_unit.sv
// ----------------------------------------------------------------------------
// cpu_branch_call_return_unit
// Executes one jump, call, return or interrupt-control instruction per
// transaction and reports next PC/SP, push request and interrupt state.
// ----------------------------------------------------------------------------
// Throughput is one instruction per clock while out_ready stays high. A decode
// stage classifies each instruction and resolves its condition into a two-entry
// queue, written at the input transaction's edge; the execute stage then loads
// the queue head into an output register, which holds the result until it is
// taken. in_ready drops
// only when the queue is full because the output side has stalled, which
// happens after three transactions are held. Interrupt enable flip-flops and
// interrupt mode are held in the execute stage and updated in instruction
// order; all three reset to zero. Unrecognized opcodes return
// recognized = 0 with PC and SP passed through and the state unchanged.
`default_nettype none

module cpu_branch_call_return_unit
	import bcru_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  opcode,
	input  wire logic        ed_prefix,
	input  wire logic [7:0]  flags,
	input  wire logic [15:0] pc,
	input  wire logic [15:0] sp,
	input  wire logic [15:0] hl,
	input  wire logic [15:0] immediate,
	input  wire logic [15:0] stack_word,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      next_pc,
	output logic [15:0]      next_sp,
	output logic             push_valid,
	output logic [15:0]      push_word,
	output logic             taken,
	output logic [2:0]       extra_cycles,
	output logic             iff1_out,
	output logic             iff2_out,
	output logic [1:0]       int_mode_out,
	output logic             recognized
);

	entry_t dec_entry;
	entry_t q_head;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;

	assign in_ready = ~q_full;

	// Decode
	bcru_front u_front (
		.opcode     (opcode),
		.ed_prefix  (ed_prefix),
		.flags      (flags),
		.pc         (pc),
		.sp         (sp),
		.hl         (hl),
		.immediate  (immediate),
		.stack_word (stack_word),
		.entry      (dec_entry)
	);

	// Decoupling queue
	bcru_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid & in_ready),
		.push_data (dec_entry),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head      (q_head)
	);

	// Execute
	bcru_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.head         (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.next_sp      (next_sp),
		.push_valid   (push_valid),
		.push_word    (push_word),
		.taken        (taken),
		.extra_cycles (extra_cycles),
		.iff1_out     (iff1_out),
		.iff2_out     (iff2_out),
		.int_mode_out (int_mode_out),
		.recognized   (recognized)
	);

endmodule

`default_nettype wire

// File: sv/bcru_checker.sv
// ----------------------------------------------------------------------------
// bcru_checker
// Port-level checks for the branch/call/return unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcru_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] next_pc,
	input wire logic        push_valid,
	input wire logic        taken,
	input wire logic [2:0]  extra_cycles,
	input wire logic [1:0]  int_mode_out,
	input wire logic        recognized
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_pc))
		else $error("result changed while stalled");

	// A push only comes from a taken call
	a_push_call: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && push_valid |-> taken && recognized && extra_cycles == 3'd7)
		else $error("push without taken call");

	// Unrecognized instructions have no side effects on control flow
	a_unrec_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recognized |-> !taken && !push_valid && extra_cycles == 3'd0)
		else $error("unrecognized opcode reported control flow");

	// Extra cycles only for taken transfers, and only 6 or 7
	a_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && extra_cycles != 3'd0 |->
			taken && (extra_cycles == 3'd6 || extra_cycles == 3'd7))
		else $error("bad extra cycle count");

	// Interrupt mode never reaches the unused code
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		int_mode_out != 2'd3)
		else $error("invalid interrupt mode");

endmodule

bind cpu_branch_call_return_unit bcru_checker u_bcru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.next_pc      (next_pc),
	.push_valid   (push_valid),
	.taken        (taken),
	.extra_cycles (extra_cycles),
	.int_mode_out (int_mode_out),
	.recognized   (recognized)
);

`default_nettype wire

// File: tb/cpu_branch_call_return_unit_tb.sv
// ----------------------------------------------------------------------------
// cpu_branch_call_return_unit_tb
// Self-checking bench for the branch/call/return unit. A directed table covers
// each instruction class, every condition code, address wrap, the prefixed
// interrupt-mode forms and unrecognized opcodes. Random instruction streams
// follow, run under several sender-idle and receiver-stall mixes. Every
// accepted transaction is run through a behavioral model of the unit, and each
// result is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module cpu_branch_call_return_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bcru_pkg::*;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 10;
	localparam int REPORT_MAX      = 10;

	// Opcodes outside the unit's set, used to exercise the unrecognized path
	localparam logic [7:0] OP_IM_ALIAS = 8'h4E;
	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_RST38    = 8'hFF;

	// Condition selector, opcode bits 5..3
	typedef enum logic [2:0] {
		CC_NZ, CC_Z, CC_NC, CC_C, CC_PO, CC_PE, CC_P, CC_M
	} cc_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic        ed_prefix;
		logic [7:0]  flags;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [15:0] hl;
		logic [15:0] immediate;
		logic [15:0] stack_word;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] next_sp;
		logic        push_valid;
		logic [15:0] push_word;
		logic        taken;
		logic [2:0]  extra_cycles;
		logic        iff1;
		logic        iff2;
		logic [1:0]  int_mode;
		logic        recognized;
	} result_t;

	typedef struct packed {
		instr_t  instr;
		logic    typed;
		result_t res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  opcode;
	logic        ed_prefix;
	logic [7:0]  flags;
	logic [15:0] pc;
	logic [15:0] sp;
	logic [15:0] hl;
	logic [15:0] immediate;
	logic [15:0] stack_word;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] next_pc;
	logic [15:0] next_sp;
	logic        push_valid;
	logic [15:0] push_word;
	logic        taken;
	logic [2:0]  extra_cycles;
	logic        iff1_out;
	logic        iff2_out;
	logic [1:0]  int_mode_out;
	logic        recognized;

	// Interrupt state as the model tracks it
	logic       iff1_q;
	logic       iff2_q;
	logic [1:0] im_q;

	result_t pending_results[$];
	int      n_fail;
	int      snd_idle_pct;
	int      rcv_stall_pct;
	bit      hold_req;
	int      idle_cycles;

	cpu_branch_call_return_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.ed_prefix    (ed_prefix),
		.flags        (flags),
		.pc           (pc),
		.sp           (sp),
		.hl           (hl),
		.immediate    (immediate),
		.stack_word   (stack_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_pc      (next_pc),
		.next_sp      (next_sp),
		.push_valid   (push_valid),
		.push_word    (push_word),
		.taken        (taken),
		.extra_cycles (extra_cycles),
		.iff1_out     (iff1_out),
		.iff2_out     (iff2_out),
		.int_mode_out (int_mode_out),
		.recognized   (recognized)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] cc_op(input logic [7:0] base, input logic [2:0] cc);
		return base | {2'b00, cc, 3'b000};
	endfunction

	// Even selector tests flag clear, odd selector tests flag set
	function automatic logic cc_holds(input logic [7:0] op, input logic [7:0] f);
		logic [2:0] sel;
		logic       flag_v;
		sel = op[5:3];
		case (sel[2:1])
			2'd0:    flag_v = f[FLG_Z];
			2'd1:    flag_v = f[FLG_C];
			2'd2:    flag_v = f[FLG_PV];
			default: flag_v = f[FLG_S];
		endcase
		return sel[0] ? flag_v : !flag_v;
	endfunction

	// Executes one instruction against the tracked interrupt state
	function automatic result_t exec_ctrl_flow(input instr_t i);
		result_t r;
		r = '0;
		r.next_pc = i.pc;
		r.next_sp = i.sp;
		r.recognized = 1'b1;
		if (i.ed_prefix) begin
			if (i.opcode == OP_IM0) im_q = IM_MODE0;
			else if (i.opcode == OP_IM1) im_q = IM_MODE1;
			else if (i.opcode == OP_IM2) im_q = IM_MODE2;
			else r.recognized = 1'b0;
			if (r.recognized) r.next_pc = i.pc + LEN2;
		end else if ((i.opcode & OP_MASK_CC) == OP_JP_CC || i.opcode == OP_JP) begin
			if (i.opcode == OP_JP || cc_holds(i.opcode, i.flags)) begin
				r.next_pc = i.immediate;
				r.taken = 1'b1;
			end else begin
				r.next_pc = i.pc + LEN3;
			end
		end else if (i.opcode == OP_JP_HL) begin
			r.next_pc = i.hl;
			r.taken = 1'b1;
		end else if ((i.opcode & OP_MASK_CC) == OP_CALL_CC || i.opcode == OP_CALL) begin
			if (i.opcode == OP_CALL || cc_holds(i.opcode, i.flags)) begin
				r.next_sp = i.sp - SP_STEP;
				r.push_valid = 1'b1;
				r.push_word = i.pc + LEN3;
				r.next_pc = i.immediate;
				r.taken = 1'b1;
				r.extra_cycles = EXTRA_CALL;
			end else begin
				r.next_pc = i.pc + LEN3;
			end
		end else if ((i.opcode & OP_MASK_CC) == OP_RET_CC) begin
			if (cc_holds(i.opcode, i.flags)) begin
				r.next_pc = i.stack_word;
				r.next_sp = i.sp + SP_STEP;
				r.taken = 1'b1;
				r.extra_cycles = EXTRA_RETC;
			end else begin
				r.next_pc = i.pc + LEN1;
			end
		end else if (i.opcode == OP_RET) begin
			r.next_pc = i.stack_word;
			r.next_sp = i.sp + SP_STEP;
			r.taken = 1'b1;
		end else if (i.opcode == OP_DI) begin
			iff1_q = 1'b0;
			iff2_q = 1'b0;
			r.next_pc = i.pc + LEN1;
		end else if (i.opcode == OP_EI) begin
			iff1_q = 1'b1;
			iff2_q = 1'b1;
			r.next_pc = i.pc + LEN1;
		end else begin
			r.recognized = 1'b0;
		end
		r.iff1 = iff1_q;
		r.iff2 = iff2_q;
		r.int_mode = im_q;
		return r;
	endfunction

	// Mostly random words, with the address extremes mixed in
	function automatic logic [15:0] rand_word();
		case ($urandom_range(15))
			0:       return 16'h0000;
			1:       return 16'h0001;
			2:       return 16'hFFFE;
			3:       return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Offer one transaction, wait for it to be taken, record its prediction
	task automatic issue_instr(input instr_t i, input logic use_typed, input result_t typed_r);
		result_t r;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= i.opcode;
		ed_prefix  <= i.ed_prefix;
		flags      <= i.flags;
		pc         <= i.pc;
		sp         <= i.sp;
		hl         <= i.hl;
		immediate  <= i.immediate;
		stack_word <= i.stack_word;
		do @(posedge clk); while (!(in_valid && in_ready));
		r = exec_ctrl_flow(i);
		pending_results.push_back(use_typed ? typed_r : r);
	endtask

	// Random instruction stream: mostly control-flow opcodes, some noise
	task automatic run_random(input int count);
		instr_t     i;
		logic [2:0] cc;
		for (int k = 0; k < count; k++) begin
			cc = 3'($urandom_range(7));
			i.opcode = 8'($urandom_range(255));
			i.ed_prefix = 1'b0;
			i.flags = 8'($urandom_range(255));
			i.pc = rand_word();
			i.sp = rand_word();
			i.hl = rand_word();
			i.immediate = rand_word();
			i.stack_word = rand_word();
			case ($urandom_range(15))
				0, 1: i.opcode = cc_op(OP_JP_CC, cc);
				2:    i.opcode = OP_JP;
				3:    i.opcode = OP_JP_HL;
				4, 5: i.opcode = cc_op(OP_CALL_CC, cc);
				6:    i.opcode = OP_CALL;
				7, 8: i.opcode = cc_op(OP_RET_CC, cc);
				9:    i.opcode = OP_RET;
				10:   i.opcode = OP_DI;
				11:   i.opcode = OP_EI;
				12: begin
					i.ed_prefix = 1'b1;
					case ($urandom_range(2))
						0:       i.opcode = OP_IM0;
						1:       i.opcode = OP_IM1;
						default: i.opcode = OP_IM2;
					endcase
				end
				13:      i.ed_prefix = 1'b1;
				14:      i.ed_prefix = ($urandom_range(3) == 0);
				default: ;
			endcase
			issue_instr(i, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int snd, input int rcv, input int count);
		snd_idle_pct = snd;
		rcv_stall_pct = rcv;
		run_random(count);
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Receiver side: random stalls, plus a long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Result checking against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{next_pc, next_sp, push_valid, push_word, taken, extra_cycles,
				iff1_out, iff2_out, int_mode_out, recognized};
			if (pending_results.size() == 0) begin
				n_fail++;
				if (n_fail <= REPORT_MAX)
					$display("%0t: result with nothing pending: pc=%h sp=%h rec=%b",
						$realtime, got.next_pc, got.next_sp, got.recognized);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					n_fail++;
					if (n_fail <= REPORT_MAX) begin
						$display("%0t: mismatch", $realtime);
						$display("  exp pc=%h sp=%h push=%b/%h tk=%b ex=%0d iff=%b%b im=%0d rec=%b",
							want.next_pc, want.next_sp, want.push_valid, want.push_word,
							want.taken, want.extra_cycles, want.iff1, want.iff2,
							want.int_mode, want.recognized);
						$display("  got pc=%h sp=%h push=%b/%h tk=%b ex=%0d iff=%b%b im=%0d rec=%b",
							got.next_pc, got.next_sp, got.push_valid, got.push_word,
							got.taken, got.extra_cycles, got.iff1, got.iff2,
							got.int_mode, got.recognized);
					end
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		row_t dir_tab[$];
		n_fail = 0;
		hold_req = 1'b0;
		idle_cycles = 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		opcode     <= OP_NOP;
		ed_prefix  <= 1'b0;
		flags      <= '0;
		pc         <= '0;
		sp         <= '0;
		hl         <= '0;
		immediate  <= '0;
		stack_word <= '0;

		// Directed table; typed results only where obvious
		dir_tab.push_back('{'{OP_JP, 1'b0, 8'h00, 16'hFFFF, 16'h1000, 16'h0000, 16'h0000,
			16'h0000}, 1'b1, '{16'h0000, 16'h1000, 1'b0, 16'h0000, 1'b1, EXTRA_NONE,
			1'b0, 1'b0, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_NZ), 1'b0, 8'h40, 16'hFFFE, 16'h1000,
			16'h0000, 16'h5555, 16'h0000}, 1'b1, '{16'h0001, 16'h1000, 1'b0, 16'h0000,
			1'b0, EXTRA_NONE, 1'b0, 1'b0, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_M), 1'b0, 8'h80, 16'h1234, 16'h1000,
			16'h0000, 16'h8000, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_P), 1'b0, 8'h80, 16'h1234, 16'h1000,
			16'h0000, 16'h8000, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_PO), 1'b0, 8'h04, 16'h2000, 16'h1000,
			16'h0000, 16'h7FFF, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_PE), 1'b0, 8'h04, 16'h2000, 16'h1000,
			16'h0000, 16'h7FFF, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_C), 1'b0, 8'h01, 16'hFFFD, 16'h1000,
			16'h0000, 16'hAAAA, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_JP_CC, CC_NC), 1'b0, 8'h01, 16'hFFFD, 16'h1000,
			16'h0000, 16'hAAAA, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{OP_JP_HL, 1'b0, 8'h00, 16'h4000, 16'h2000, 16'hFFFF, 16'h0001,
			16'h0002}, 1'b1, '{16'hFFFF, 16'h2000, 1'b0, 16'h0000, 1'b1, EXTRA_NONE,
			1'b0, 1'b0, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{OP_CALL, 1'b0, 8'h00, 16'hFFFE, 16'h0001, 16'h0000, 16'hABCD,
			16'h0000}, 1'b1, '{16'hABCD, 16'hFFFF, 1'b1, 16'h0001, 1'b1, EXTRA_CALL,
			1'b0, 1'b0, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{cc_op(OP_CALL_CC, CC_Z), 1'b0, 8'h00, 16'h0100, 16'h0000,
			16'h0000, 16'h0300, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_CALL_CC, CC_PE), 1'b0, 8'h04, 16'h0100, 16'h0000,
			16'h0000, 16'h0300, 16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_CALL_CC, CC_M), 1'b0, 8'hFF, 16'hFFFD, 16'h8000,
			16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0});
		dir_tab.push_back('{'{OP_RET, 1'b0, 8'h00, 16'h0200, 16'hFFFF, 16'h0000, 16'h0000,
			16'h1234}, 1'b1, '{16'h1234, 16'h0001, 1'b0, 16'h0000, 1'b1, EXTRA_NONE,
			1'b0, 1'b0, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{cc_op(OP_RET_CC, CC_C), 1'b0, 8'h01, 16'h0300, 16'hFFFE,
			16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_RET_CC, CC_NC), 1'b0, 8'h01, 16'hFFFF, 16'hFFFE,
			16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0});
		dir_tab.push_back('{'{cc_op(OP_RET_CC, CC_PO), 1'b0, 8'h00, 16'h0400, 16'h0100,
			16'h0000, 16'h0000, 16'h5A5A}, 1'b0, '0});
		dir_tab.push_back('{'{OP_EI, 1'b0, 8'h00, 16'hFFFF, 16'h3000, 16'h0000, 16'h0000,
			16'h0000}, 1'b1, '{16'h0000, 16'h3000, 1'b0, 16'h0000, 1'b0, EXTRA_NONE,
			1'b1, 1'b1, IM_MODE0, 1'b1}});
		dir_tab.push_back('{'{OP_IM2, 1'b1, 8'h00, 16'hFFFF, 16'h3000, 16'h0000, 16'h0000,
			16'h0000}, 1'b1, '{16'h0001, 16'h3000, 1'b0, 16'h0000, 1'b0, EXTRA_NONE,
			1'b1, 1'b1, IM_MODE2, 1'b1}});
		dir_tab.push_back('{'{OP_IM_ALIAS, 1'b1, 8'h00, 16'h5000, 16'h3000, 16'h0000,
			16'h0000, 16'h0000}, 1'b1, '{16'h5000, 16'h3000, 1'b0, 16'h0000, 1'b0,
			EXTRA_NONE, 1'b1, 1'b1, IM_MODE2, 1'b0}});
		dir_tab.push_back('{'{OP_JP, 1'b1, 8'hFF, 16'h6000, 16'h3000, 16'h0000, 16'h1111,
			16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{OP_IM1, 1'b1, 8'h00, 16'h7000, 16'h3000, 16'h0000, 16'h0000,
			16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{OP_DI, 1'b0, 8'h00, 16'h7002, 16'h3000, 16'h0000, 16'h0000,
			16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{OP_IM0, 1'b1, 8'h00, 16'h7003, 16'h3000, 16'h0000, 16'h0000,
			16'h0000}, 1'b0, '0});
		dir_tab.push_back('{'{OP_RST38, 1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF}, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0, EXTRA_NONE,
			1'b0, 1'b0, IM_MODE0, 1'b0}});
		dir_tab.push_back('{'{OP_NOP, 1'b0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000}, 1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		iff1_q = 1'b0;
		iff2_q = 1'b0;
		im_q = IM_MODE0;
		@(posedge clk);

		foreach (dir_tab[n])
			issue_instr(dir_tab[n].instr, dir_tab[n].typed, dir_tab[n].res);
		drain();

		// Back-pressure: receiver holds off while the sender keeps offering
		hold_req = 1'b1;
		run_random(16);
		drain();

		run_phase(0, 0, 420);
		run_phase(80, 0, 420);
		run_phase(0, 80, 420);
		run_phase(12, 12, 420);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
sv/bcru_pkg.sv
sv/bcru_front.sv
sv/bcru_queue.sv
sv/bcru_back.sv
sv/cpu_branch_call_return_unit.sv
sv/bcru_checker.sv
tb/cpu_branch_call_return_unit_tb.sv
